@@ hw/rtl/mvpd_pkg.sv @@
package mvpd_pkg;

  typedef enum logic [1:0] {
    ST_NOCAR    = 2'd0,
    ST_ARRIVING = 2'd1,
    ST_CAR      = 2'd2,
    ST_SPARE    = 2'd3
  } feat_state_e;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_SQ_DEV,
    SEQ_RT_DEV,
    SEQ_SQ_INT,
    SEQ_RT_INT,
    SEQ_DECIDE,
    SEQ_OUT
  } seq_state_e;

  localparam int unsigned NUM_REGS = 7;
  localparam int unsigned REG_W    = 13;
  localparam int unsigned IDX_W    = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_DEV_THR  = 3'd0,
    REG_EXT_THR  = 3'd1,
    REG_INT_THR  = 3'd2,
    REG_X_BASE   = 3'd3,
    REG_Y_BASE   = 3'd4,
    REG_EXT_BASE = 3'd5,
    REG_INT_BASE = 3'd6,
    REG_NONE     = 3'd7
  } reg_idx_e;

  localparam int unsigned VAL_W  = 13;
  localparam int unsigned EXTV_W = 12;
  localparam logic [VAL_W-1:0]  VAL_MAX  = 13'h1FFF;
  localparam logic [EXTV_W-1:0] EXTV_MAX = 12'hFFF;

  // debounce limits per feature: deviation, extremum, intensity
  localparam logic [3:0] ENTER_LIM [3] = '{4'd5, 4'd5, 4'd8};
  localparam logic [4:0] FALL_LIM  [3] = '{5'd10, 5'd20, 5'd10};
  localparam logic [4:0] REL_LIM   [3] = '{5'd15, 5'd25, 5'd30};

  localparam logic [9:0] CAR_SET_CNT   = 10'd60;
  localparam logic [9:0] SNAP_CNT      = 10'd600;
  localparam logic [7:0] EMPTY_CLR_CNT = 8'd60;
  localparam logic [7:0] CAL_CNT       = 8'd240;
  localparam logic [5:0] DRIFT_CNT     = 6'd60;
  localparam int         DRIFT_MARGIN  = 50;

  typedef struct packed {
    logic [VAL_W-1:0]  dev;
    logic [EXTV_W-1:0] ext;
    logic [VAL_W-1:0]  inten;
  } feat_t;

  typedef struct packed {
    logic        occupied;
    logic        state_changed;
    logic        calibrate_request;
    feat_state_e dev_st;
    feat_state_e ext_st;
    feat_state_e int_st;
  } decision_t;

endpackage

@@ hw/rtl/mvpd_if.sv @@
interface mvpd_in_if #(parameter int SAMPLE_BITS = 12);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] x_sample;
  logic [SAMPLE_BITS-1:0] y_sample;
  modport source (output valid, x_sample, y_sample, input ready);
  modport sink   (input valid, x_sample, y_sample, output ready);
endinterface

interface mvpd_out_if;
  logic        valid;
  logic        ready;
  logic        occupied;
  logic        state_changed;
  logic        calibrate_request;
  logic [1:0]  deviation_state;
  logic [1:0]  extremum_state;
  logic [1:0]  intensity_state;
  logic [12:0] deviation_value;
  logic [11:0] extremum_value;
  logic [12:0] intensity_value;
  modport source (output valid, occupied, state_changed, calibrate_request,
                  deviation_state, extremum_state, intensity_state,
                  deviation_value, extremum_value, intensity_value,
                  input ready);
  modport sink   (input valid, occupied, state_changed, calibrate_request,
                  deviation_state, extremum_state, intensity_state,
                  deviation_value, extremum_value, intensity_value,
                  output ready);
endinterface

@@ hw/rtl/mvpd_sqrt.sv @@
// Shared unit: squares two operands (one multiplier, reused) and sums them,
// then takes floor sqrt one result bit per cycle.
module mvpd_sqrt #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [SAMPLE_BITS-1:0] a_i,
  input  logic [SAMPLE_BITS-1:0] b_i,
  output logic                   done_o,
  output logic [SAMPLE_BITS:0]   root_o
);
  localparam int RW = SAMPLE_BITS + 1;   // root width
  localparam int SW = 2 * RW;            // sum width (even)
  localparam int CW = $clog2(RW + 3);

  typedef enum logic [1:0] {U_IDLE, U_SQB, U_ROOT} u_state_e;

  u_state_e               st_q, st_d;
  logic [SAMPLE_BITS-1:0] b_q;
  logic [SW-1:0]          dat_q, dat_d;
  logic [RW+1:0]          rem_q, rem_d;
  logic [RW-1:0]          res_q, res_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [SAMPLE_BITS-1:0] mul_op;
  logic [2*SAMPLE_BITS-1:0] prod;
  logic [RW+1:0]          trial;
  logic [RW+1:0]          shl;

  assign mul_op = (st_q == U_SQB) ? b_q : a_i;
  assign prod   = mul_op * mul_op;
  // partial remainder with the next two bits of the sum brought in
  assign shl    = {rem_q[RW-1:0], dat_q[SW-1 -: 2]};
  assign trial  = {res_q, 2'b01};

  always_comb begin
    st_d  = st_q;
    dat_d = dat_q;
    rem_d = rem_q;
    res_d = res_q;
    cnt_d = cnt_q;
    unique case (st_q)
      U_IDLE: begin
        if (start_i) begin
          st_d  = U_SQB;
          dat_d = SW'(prod);
        end
      end
      U_SQB: begin
        dat_d = dat_q + SW'(prod);
        rem_d = '0;
        res_d = '0;
        cnt_d = '0;
        st_d  = U_ROOT;
      end
      U_ROOT: begin
        // restoring step: one root bit per cycle
        dat_d = {dat_q[SW-3:0], 2'b00};
        if (shl >= trial) begin
          rem_d = shl - trial;
          res_d = {res_q[RW-2:0], 1'b1};
        end else begin
          rem_d = shl;
          res_d = {res_q[RW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(RW - 1)) st_d = U_IDLE;
      end
      default: st_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= U_IDLE;
      cnt_q <= '0;
      b_q   <= '0;
      dat_q <= '0;
      rem_q <= '0;
      res_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      if (st_q == U_IDLE && start_i) b_q <= b_i;
      dat_q <= dat_d;
      rem_q <= rem_d;
      res_q <= res_d;
    end
  end

  assign done_o = (st_q == U_ROOT) && (cnt_q == CW'(RW - 1));
  assign root_o = res_d;
endmodule

@@ hw/rtl/mvpd_decide.sv @@
// Debounce machines, vote counters, snapshot and drift logic.
module mvpd_decide (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  mvpd_pkg::feat_t     feat_i,
  input  logic [12:0]         dev_thr_i,
  input  logic [12:0]         ext_thr_i,
  input  logic [12:0]         int_thr_i,
  input  logic [12:0]         int_base_i,
  output mvpd_pkg::decision_t dec_o
);
  mvpd_pkg::feat_state_e st_q [3], st_d [3];
  logic [3:0] ent_q [3], ent_d [3];
  logic [4:0] fal_q [3], fal_d [3];
  logic [4:0] rel_q [3], rel_d [3];
  logic [9:0] carv_q, carv_d;
  logic [7:0] empv_q, empv_d;
  logic [5:0] edr_q, edr_d, ddr_q, ddr_d;
  logic [12:0] snap_e_q, snap_e_d, snap_d_q, snap_d_d;
  logic snap_q, snap_d, occ_q, occ_d, prev_q, prev_d, cal_d;
  logic [2:0] above;
  logic [12:0] idiff;
  logic [1:0] ncar, nnone;

  assign idiff = (feat_i.inten >= int_base_i) ? feat_i.inten - int_base_i
                                              : int_base_i - feat_i.inten;
  assign above[0] = feat_i.dev > dev_thr_i;
  assign above[1] = {1'b0, feat_i.ext} > ext_thr_i;
  assign above[2] = idiff > int_thr_i;

  always_comb begin
    for (int f = 0; f < 3; f++) begin
      st_d[f] = st_q[f]; ent_d[f] = ent_q[f];
      fal_d[f] = fal_q[f]; rel_d[f] = rel_q[f];
      if (above[f]) begin
        if (st_q[f] != mvpd_pkg::ST_CAR) begin
          ent_d[f] = ent_q[f] + 1'b1;
          if (ent_d[f] > mvpd_pkg::ENTER_LIM[f]) begin
            st_d[f] = mvpd_pkg::ST_CAR; ent_d[f] = '0;
          end else st_d[f] = mvpd_pkg::ST_ARRIVING;
        end
      end else if (st_q[f] == mvpd_pkg::ST_ARRIVING) begin
        fal_d[f] = fal_q[f] + 1'b1;
        if (fal_d[f] > mvpd_pkg::FALL_LIM[f]) begin
          st_d[f] = mvpd_pkg::ST_NOCAR; fal_d[f] = '0; ent_d[f] = '0;
        end
      end else if (st_q[f] != mvpd_pkg::ST_NOCAR) begin
        rel_d[f] = rel_q[f] + 1'b1;
        if (rel_d[f] > mvpd_pkg::REL_LIM[f]) begin
          st_d[f] = mvpd_pkg::ST_NOCAR; rel_d[f] = '0;
        end
      end
    end

    ncar = 2'(st_d[0] == mvpd_pkg::ST_CAR) + 2'(st_d[1] == mvpd_pkg::ST_CAR)
         + 2'(st_d[2] == mvpd_pkg::ST_CAR);
    occ_d = occ_q; snap_e_d = snap_e_q; snap_d_d = snap_d_q; snap_d = snap_q;
    if (ncar >= 2'd2) begin
      carv_d = carv_q + 1'b1;
      if (carv_d > mvpd_pkg::CAR_SET_CNT) occ_d = 1'b1;
    end else carv_d = '0;
    if (carv_d == mvpd_pkg::SNAP_CNT) begin
      snap_e_d = {1'b0, feat_i.ext}; snap_d_d = feat_i.dev;
      snap_d = 1'b1; carv_d = '0;
    end

    edr_d = edr_q; ddr_d = ddr_q;
    if (snap_d) begin
      if (14'(snap_e_d) > 14'({1'b0, feat_i.ext}) + 14'(mvpd_pkg::DRIFT_MARGIN)) begin
        edr_d = edr_q + 1'b1;
        if (edr_d > mvpd_pkg::DRIFT_CNT) begin
          st_d[1] = mvpd_pkg::ST_NOCAR; edr_d = '0;
          ent_d[1] = '0; fal_d[1] = '0; rel_d[1] = '0;
        end
      end else edr_d = '0;
      if (14'(snap_d_d) > 14'(feat_i.dev) + 14'(mvpd_pkg::DRIFT_MARGIN)) begin
        ddr_d = ddr_q + 1'b1;
        if (ddr_d > mvpd_pkg::DRIFT_CNT) begin
          st_d[0] = mvpd_pkg::ST_NOCAR; ddr_d = '0;
          ent_d[0] = '0; fal_d[0] = '0; rel_d[0] = '0;
        end
      end else ddr_d = '0;
    end

    nnone = 2'(st_d[0] == mvpd_pkg::ST_NOCAR) + 2'(st_d[1] == mvpd_pkg::ST_NOCAR)
          + 2'(st_d[2] == mvpd_pkg::ST_NOCAR);
    cal_d = 1'b0;
    if (nnone >= 2'd2) begin
      if (empv_q > mvpd_pkg::EMPTY_CLR_CNT) occ_d = 1'b0;
      empv_d = empv_q + 1'b1;
    end else empv_d = '0;
    if (empv_d > mvpd_pkg::CAL_CNT) begin
      empv_d = '0; cal_d = 1'b1;
    end
    prev_d = occ_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int f = 0; f < 3; f++) begin
        st_q[f] <= mvpd_pkg::ST_NOCAR;
        ent_q[f] <= '0; fal_q[f] <= '0; rel_q[f] <= '0;
      end
      carv_q <= '0; empv_q <= '0; edr_q <= '0; ddr_q <= '0;
      snap_e_q <= '0; snap_d_q <= '0; snap_q <= 1'b0;
      occ_q <= 1'b0; prev_q <= 1'b0;
      dec_o <= '0;
    end else if (step_i) begin
      for (int f = 0; f < 3; f++) begin
        st_q[f] <= st_d[f];
        ent_q[f] <= ent_d[f]; fal_q[f] <= fal_d[f]; rel_q[f] <= rel_d[f];
      end
      carv_q <= carv_d; empv_q <= empv_d; edr_q <= edr_d; ddr_q <= ddr_d;
      snap_e_q <= snap_e_d; snap_d_q <= snap_d_d; snap_q <= snap_d;
      occ_q <= occ_d; prev_q <= prev_d;
      dec_o.occupied          <= occ_d;
      dec_o.state_changed     <= occ_d != prev_q;
      dec_o.calibrate_request <= cal_d;
      dec_o.dev_st            <= st_d[0];
      dec_o.ext_st            <= st_d[1];
      dec_o.int_st            <= st_d[2];
    end
  end
endmodule

@@ hw/rtl/magnetic_vehicle_presence_detector.sv @@
// Magnetic vehicle presence detector. Takes one X/Y sample pair, returns one
// decision with three feature values. With W the larger of SAMPLE_BITS and 12,
// one shared squarer and a one-bit-per-cycle square-root unit are run twice,
// first for the deviation, then for the intensity, each pass a start state, a
// summing step and W+1 root steps, followed by a decision state and the
// result state. The block takes no new sample until the result is
// transferred, so an output stall delays the next sample by its length.
// Configuration writes take effect at once and must only be made while idle.
module magnetic_vehicle_presence_detector #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  mvpd_in_if.sink     in_if,
  mvpd_out_if.source  out_if
);
  localparam int SB = SAMPLE_BITS;
  // datapath width: baselines are 12 bits whatever the sample width
  localparam int DW = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;

  logic [12:0] regs_q [mvpd_pkg::NUM_REGS];
  mvpd_pkg::seq_state_e st_q, st_d;
  logic [SB-1:0] x_q, y_q;
  logic [DW-1:0] ua, ub;
  logic [DW:0]   root;
  logic          sq_start, sq_done;
  mvpd_pkg::feat_t feat_q;
  mvpd_pkg::decision_t dec;
  logic [DW:0] xb, yb, ex_base;
  logic [DW-1:0] dx, dy;
  logic [SB-1:0] dxy;
  logic [DW:0] ext_w;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q[0] <= 13'd100; regs_q[1] <= 13'd100; regs_q[2] <= 13'd100;
      regs_q[3] <= 13'd2048; regs_q[4] <= 13'd2048; regs_q[5] <= 13'd0;
      regs_q[6] <= 13'd2896;
    end else if (cfg_we_i) begin
      unique case (mvpd_pkg::reg_idx_e'(cfg_idx_i))
        mvpd_pkg::REG_DEV_THR:  regs_q[0] <= cfg_data_i;
        mvpd_pkg::REG_EXT_THR:  regs_q[1] <= cfg_data_i;
        mvpd_pkg::REG_INT_THR:  regs_q[2] <= cfg_data_i;
        mvpd_pkg::REG_X_BASE:   regs_q[3] <= {1'b0, cfg_data_i[11:0]};
        mvpd_pkg::REG_Y_BASE:   regs_q[4] <= {1'b0, cfg_data_i[11:0]};
        mvpd_pkg::REG_EXT_BASE: regs_q[5] <= {1'b0, cfg_data_i[11:0]};
        mvpd_pkg::REG_INT_BASE: regs_q[6] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // offsets; baselines are 12-bit, sized to datapath width plus one
  assign xb = (DW + 1)'(regs_q[3][11:0]);
  assign yb = (DW + 1)'(regs_q[4][11:0]);
  assign ex_base = (DW + 1)'(regs_q[5][11:0]);
  always_comb begin
    logic [DW:0] xs, ys, a;
    xs = (DW + 1)'(x_q); ys = (DW + 1)'(y_q);
    a = (xs >= xb) ? xs - xb : xb - xs; dx = a[DW-1:0];
    a = (ys >= yb) ? ys - yb : yb - ys; dy = a[DW-1:0];
    dxy = (x_q >= y_q) ? x_q - y_q : y_q - x_q;
    a = (DW + 1)'(dxy);
    ext_w = (a >= ex_base) ? a - ex_base : ex_base - a;
  end

  // sequencer
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      mvpd_pkg::SEQ_IDLE:   if (in_if.valid) st_d = mvpd_pkg::SEQ_SQ_DEV;
      mvpd_pkg::SEQ_SQ_DEV: st_d = mvpd_pkg::SEQ_RT_DEV;
      mvpd_pkg::SEQ_RT_DEV: if (sq_done) st_d = mvpd_pkg::SEQ_SQ_INT;
      mvpd_pkg::SEQ_SQ_INT: st_d = mvpd_pkg::SEQ_RT_INT;
      mvpd_pkg::SEQ_RT_INT: if (sq_done) st_d = mvpd_pkg::SEQ_DECIDE;
      mvpd_pkg::SEQ_DECIDE: st_d = mvpd_pkg::SEQ_OUT;
      mvpd_pkg::SEQ_OUT:    if (out_if.ready) st_d = mvpd_pkg::SEQ_IDLE;
      default:              st_d = mvpd_pkg::SEQ_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_if.ready  = (st_q == mvpd_pkg::SEQ_IDLE);
    out_if.valid = (st_q == mvpd_pkg::SEQ_OUT);
    sq_start = (st_q == mvpd_pkg::SEQ_SQ_DEV) || (st_q == mvpd_pkg::SEQ_SQ_INT);
    ua = (st_q == mvpd_pkg::SEQ_SQ_INT) ? DW'(x_q) : dx;
    ub = (st_q == mvpd_pkg::SEQ_SQ_INT) ? DW'(y_q) : dy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= mvpd_pkg::SEQ_IDLE;
    else         st_q <= st_d;
  end

  // sample and feature registers
  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      x_q <= in_if.x_sample; y_q <= in_if.y_sample;
    end
    if (st_q == mvpd_pkg::SEQ_SQ_DEV)
      feat_q.ext <= (ext_w > (DW + 1)'(mvpd_pkg::EXTV_MAX)) ? mvpd_pkg::EXTV_MAX
                                                            : 12'(ext_w);
    if (sq_done) begin
      if (st_q == mvpd_pkg::SEQ_RT_DEV)
        feat_q.dev <= (root > (DW + 1)'(mvpd_pkg::VAL_MAX)) ?
                      mvpd_pkg::VAL_MAX : 13'(root);
      else
        feat_q.inten <= (root > (DW + 1)'(mvpd_pkg::VAL_MAX)) ?
                        mvpd_pkg::VAL_MAX : 13'(root);
    end
  end

  mvpd_sqrt #(.SAMPLE_BITS(DW)) u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .a_i(ua), .b_i(ub),
    .done_o(sq_done), .root_o(root)
  );

  mvpd_decide u_decide (
    .clk_i, .rst_ni, .step_i(st_q == mvpd_pkg::SEQ_DECIDE), .feat_i(feat_q),
    .dev_thr_i(regs_q[0]), .ext_thr_i(regs_q[1]), .int_thr_i(regs_q[2]),
    .int_base_i(regs_q[6]), .dec_o(dec)
  );

  assign out_if.occupied          = dec.occupied;
  assign out_if.state_changed     = dec.state_changed;
  assign out_if.calibrate_request = dec.calibrate_request;
  assign out_if.deviation_state   = dec.dev_st;
  assign out_if.extremum_state    = dec.ext_st;
  assign out_if.intensity_state   = dec.int_st;
  assign out_if.deviation_value   = feat_q.dev;
  assign out_if.extremum_value    = feat_q.ext;
  assign out_if.intensity_value   = feat_q.inten;
endmodule
